### rtl/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and codes for the timestep work drain tracker.
// ----------------------------------------------------------------------------
package tdt_pkg;

  typedef enum logic [2:0] {
    CMD_OPEN    = 3'd0,
    CMD_SEAL    = 3'd1,
    CMD_ACQUIRE = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_ALREADY_OPEN   = 3'd1,
    ST_NOT_OPEN       = 3'd2,
    ST_ALREADY_SEALED = 3'd3,
    ST_ACQ_AFTER_SEAL = 3'd4,
    ST_UNDERFLOW      = 3'd5,
    ST_BAD_KIND       = 3'd6,
    ST_OVERFLOW       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/tdt_ctrl.sv
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer: clearing pass after reset, then accept / execute per word.
// ----------------------------------------------------------------------------
module tdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tdt_pkg::dp_stat_t stat_i,
  output tdt_pkg::dp_cmd_t  cmd_o
);

  tdt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_o.clr_step = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.commit   = 1'b0;
    in_stall       = 1'b1;
    unique case (state_r)
      tdt_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_nxt = tdt_pkg::S_IDLE;
        end
      end
      tdt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = tdt_pkg::S_EXEC;
        end
      end
      tdt_pkg::S_EXEC: begin
        // hold the looked-up word until the output register can take it
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = tdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tdt_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

### rtl/tdt_datapath.sv
// ----------------------------------------------------------------------------
// tdt_datapath
// Slot flag memory, counter memory, update logic and output register.
// ----------------------------------------------------------------------------
module tdt_datapath #(
  parameter int SLOTS       = 64,
  parameter int KINDS       = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tdt_pkg::dp_cmd_t  cmd_i,
  output tdt_pkg::dp_stat_t stat_o,
  input  logic [2:0]        in_cmd,
  input  logic [5:0]        in_timestep,
  input  logic [2:0]        in_kind,
  input  logic [31:0]       in_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic              out_slot_opened,
  output logic              out_slot_sealed,
  output logic              out_drained,
  output logic [31:0]       out_outstanding
);

  localparam int SW     = $clog2(SLOTS);
  localparam int KW     = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int KP     = 1 << KW;
  localparam int FW     = 2 + KINDS;
  localparam int CW     = COUNT_WIDTH;
  localparam int CDEPTH = SLOTS * KP;

  // timestep -> slot, reduced modulo SLOTS
  logic [SW-1:0] slot_tbl [64];
  for (genvar i = 0; i < 64; i++) begin : g_slot
    assign slot_tbl[i] = SW'(i % SLOTS);
  end

  logic [SW-1:0] in_slot;
  assign in_slot = slot_tbl[in_timestep];

  // clearing pass over the flag memory
  logic [SW-1:0] clr_addr_r, clr_addr_nxt;
  assign clr_addr_nxt    = cmd_i.clr_step ? clr_addr_r + SW'(1) : clr_addr_r;
  assign stat_o.clr_last = (clr_addr_r == SW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // captured command word
  logic [2:0]    cmd_r;
  logic [SW-1:0] slot_r;
  logic [2:0]    kind_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
      kind_r <= in_kind;
      cnt_r  <= CW'(in_count);
    end
  end

  // flag memory: {opened, sealed, nonzero mask}
  logic [FW-1:0] flag_mem [SLOTS];
  logic [FW-1:0] flag_q;
  logic [FW-1:0] flag_wr;

  always_ff @(posedge clk) begin
    if (cmd_i.clr_step) begin
      flag_mem[clr_addr_r] <= '0;
    end else if (cmd_i.commit) begin
      flag_mem[slot_r] <= flag_wr;
    end
    if (cmd_i.accept) begin
      flag_q <= flag_mem[in_slot];
    end
  end

  // counter memory; an entry counts only while its mask bit is set
  logic [CW-1:0] cnt_mem [CDEPTH];
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_new;
  logic          cnt_we;

  always_ff @(posedge clk) begin
    if (cmd_i.commit && cnt_we) begin
      cnt_mem[{slot_r, kind_r[KW-1:0]}] <= cnt_new;
    end
    if (cmd_i.accept) begin
      cnt_q <= cnt_mem[{in_slot, in_kind[KW-1:0]}];
    end
  end

  // update logic
  logic          cur_open;
  logic          cur_sealed;
  logic [KP-1:0] cur_mask;
  logic [KW-1:0] kidx;
  logic          kind_ok;
  logic [CW-1:0] cur_cnt;
  logic [CW:0]   sum;
  logic          n_open;
  logic          n_sealed;
  logic [KP-1:0] n_mask;
  logic [CW-1:0] after_cnt;
  tdt_pkg::status_t status;

  assign cur_open   = flag_q[FW-1];
  assign cur_sealed = flag_q[FW-2];
  assign cur_mask   = KP'(flag_q[KINDS-1:0]);
  assign kidx       = kind_r[KW-1:0];
  assign kind_ok    = (32'(kind_r) < KINDS);
  assign cur_cnt    = cur_mask[kidx] ? cnt_q : '0;
  assign sum        = {1'b0, cur_cnt} + {1'b0, cnt_r};

  always_comb begin
    n_open   = cur_open;
    n_sealed = cur_sealed;
    n_mask   = cur_mask;
    cnt_we   = 1'b0;
    cnt_new  = sum[CW-1:0];
    status   = tdt_pkg::ST_OK;
    if (cmd_r == tdt_pkg::CMD_OPEN) begin
      if (cur_open) begin
        status = tdt_pkg::ST_ALREADY_OPEN;
      end else begin
        n_open   = 1'b1;
        n_sealed = 1'b0;
        n_mask   = '0;
      end
    end else if (!cur_open) begin
      status = tdt_pkg::ST_NOT_OPEN;
    end else begin
      unique case (cmd_r)
        tdt_pkg::CMD_SEAL: begin
          if (cur_sealed) begin
            status = tdt_pkg::ST_ALREADY_SEALED;
          end else begin
            n_sealed = 1'b1;
          end
        end
        tdt_pkg::CMD_ACQUIRE: begin
          priority if (cur_sealed) begin
            status = tdt_pkg::ST_ACQ_AFTER_SEAL;
          end else if (!kind_ok) begin
            status = tdt_pkg::ST_BAD_KIND;
          end else if (sum[CW]) begin
            status = tdt_pkg::ST_OVERFLOW;
          end else begin
            cnt_we       = 1'b1;
            cnt_new      = sum[CW-1:0];
            n_mask[kidx] = |sum[CW-1:0];
          end
        end
        tdt_pkg::CMD_RELEASE: begin
          priority if (!kind_ok) begin
            status = tdt_pkg::ST_BAD_KIND;
          end else if (cnt_r > cur_cnt) begin
            status = tdt_pkg::ST_UNDERFLOW;
          end else begin
            cnt_we       = 1'b1;
            cnt_new      = cur_cnt - cnt_r;
            n_mask[kidx] = |(cur_cnt - cnt_r);
          end
        end
        default: begin
          // query, and unused codes behave as query
          if (!kind_ok) begin
            status = tdt_pkg::ST_BAD_KIND;
          end
        end
      endcase
    end
  end

  assign after_cnt = n_mask[kidx] ? (cnt_we ? cnt_new : cnt_q) : '0;
  assign flag_wr   = {n_open, n_sealed, n_mask[KINDS-1:0]};

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic        out_opened_r;
  logic        out_sealed_r;
  logic        out_drained_r;
  logic [31:0] out_outst_r;

  assign stat_o.out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt   = cmd_i.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_status_r  <= status;
      out_opened_r  <= n_open;
      out_sealed_r  <= n_sealed;
      out_drained_r <= n_open && n_sealed && !(|n_mask);
      out_outst_r   <= (n_open && kind_ok) ? 32'(after_cnt) : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_opened = out_opened_r;
  assign out_slot_sealed = out_sealed_r;
  assign out_drained     = out_drained_r;
  assign out_outstanding = out_outst_r;

endmodule

### rtl/timestep_work_drain_tracker_core.sv
// ----------------------------------------------------------------------------
// timestep_work_drain_tracker_core
// Per-timestep open/seal flags and per-kind outstanding work counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot flag memory, one slot per cycle, and
// holds in_stall high until all SLOTS slots (64 by default) are cleared. From
// then on each command word first has the slot's flags and the kind's
// counter looked up in synchronous memory, then has the read-modify-write applied
// and the output register loaded. A new word is taken while the previous result still
// sits in the output register; the apply step waits only if that result
// has not been taken. Every word yields exactly one result word.
module timestep_work_drain_tracker_core #(
  parameter int SLOTS       = 64,
  parameter int KINDS       = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_timestep,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_slot_opened,
  output logic        out_slot_sealed,
  output logic        out_drained,
  output logic [31:0] out_outstanding
);

  tdt_pkg::dp_cmd_t  dp_cmd;
  tdt_pkg::dp_stat_t dp_stat;

  tdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  tdt_datapath #(
    .SLOTS       (SLOTS),
    .KINDS       (KINDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .in_cmd          (in_cmd),
    .in_timestep     (in_timestep),
    .in_kind         (in_kind),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_opened (out_slot_opened),
    .out_slot_sealed (out_slot_sealed),
    .out_drained     (out_drained),
    .out_outstanding (out_outstanding)
  );

endmodule

### test/timestep_work_drain_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// timestep_work_drain_tracker_core_tb
// Self-checking bench for the timestep work drain tracker. A scoreboard
// mirrors the slot flags and per-kind token counters, predicts one report per
// command word and checks the reports in order. Directed words hit the error
// codes and counter limits. Random slot lifecycles (open, acquire, release,
// seal, drain) follow, mixed with noise words, under random idling on both
// sides and one long output hold.
// ----------------------------------------------------------------------------
module timestep_work_drain_tracker_core_tb;

  localparam int SLOTS         = 64;
  localparam int KINDS         = 4;
  localparam int KIND_CODE_MAX = 7;
  localparam int HOLD_LEN      = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_WORDS  = 750;
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  typedef struct {
    tdt_pkg::status_t status;
    logic             opened;
    logic             sealed;
    logic             drained;
    logic [31:0]      outstanding;
  } slot_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = tdt_pkg::CMD_QUERY;
  logic [5:0]  in_timestep = '0;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic        out_slot_opened;
  logic        out_slot_sealed;
  logic        out_drained;
  logic [31:0] out_outstanding;

  // scoreboard copy of the tracker state
  bit          slot_up   [SLOTS];
  bit          slot_shut [SLOTS];
  logic [31:0] tokens    [SLOTS][KINDS];

  slot_report_t expected_reports[$];
  int errors = 0;

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_serial = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int stall_left = 0;

  timestep_work_drain_tracker_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_timestep     (in_timestep),
    .in_kind         (in_kind),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_opened (out_slot_opened),
    .out_slot_sealed (out_slot_sealed),
    .out_drained     (out_drained),
    .out_outstanding (out_outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(40, 10);
  endfunction

  function automatic bit slot_drained(int s);
    bit all_zero;
    all_zero = 1'b1;
    for (int i = 0; i < KINDS; i++)
      if (tokens[s][i] != '0) all_zero = 1'b0;
    return slot_up[s] && slot_shut[s] && all_zero;
  endfunction

  function automatic slot_report_t track_command(logic [2:0] cmd, logic [5:0] ts,
                                                 logic [2:0] kind, logic [31:0] count);
    slot_report_t r;
    int           s;
    bit           kind_ok;
    logic [32:0]  sum;
    s = ts;
    kind_ok = kind < KINDS;
    r.status = tdt_pkg::ST_OK;
    if (cmd == tdt_pkg::CMD_OPEN) begin
      if (slot_up[s]) r.status = tdt_pkg::ST_ALREADY_OPEN;
      else begin
        slot_up[s] = 1'b1;
        slot_shut[s] = 1'b0;
        for (int i = 0; i < KINDS; i++) tokens[s][i] = '0;
      end
    end else if (!slot_up[s]) begin
      r.status = tdt_pkg::ST_NOT_OPEN;
    end else begin
      case (cmd)
        tdt_pkg::CMD_SEAL: begin
          if (slot_shut[s]) r.status = tdt_pkg::ST_ALREADY_SEALED;
          else slot_shut[s] = 1'b1;
        end
        tdt_pkg::CMD_ACQUIRE: begin
          if (slot_shut[s]) r.status = tdt_pkg::ST_ACQ_AFTER_SEAL;
          else if (!kind_ok) r.status = tdt_pkg::ST_BAD_KIND;
          else begin
            sum = {1'b0, tokens[s][kind[1:0]]} + {1'b0, count};
            if (sum[32]) r.status = tdt_pkg::ST_OVERFLOW;
            else tokens[s][kind[1:0]] = sum[31:0];
          end
        end
        tdt_pkg::CMD_RELEASE: begin
          if (!kind_ok) r.status = tdt_pkg::ST_BAD_KIND;
          else if (count > tokens[s][kind[1:0]]) r.status = tdt_pkg::ST_UNDERFLOW;
          else tokens[s][kind[1:0]] = tokens[s][kind[1:0]] - count;
        end
        // query and the spare codes
        default: begin
          if (!kind_ok) r.status = tdt_pkg::ST_BAD_KIND;
        end
      endcase
    end
    r.opened = slot_up[s];
    r.sealed = slot_shut[s];
    r.drained = slot_drained(s);
    r.outstanding = (slot_up[s] && kind_ok) ? tokens[s][kind[1:0]] : '0;
    return r;
  endfunction

  // Drives one command word and returns at the edge where it is taken.
  task automatic send_word(input logic [2:0] cmd, input logic [5:0] ts,
                           input logic [2:0] kind, input logic [31:0] count);
    int gap;
    gap = ($urandom_range(99) < tx_gap_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_timestep <= ts;
    in_kind     <= kind;
    in_count    <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_reports.push_back(track_command(cmd, ts, kind, count));
  endtask

  // Receiver: random stalls, plus a long hold whenever hold_serial moves.
  always @(posedge clk) begin
    if (hold_taken != hold_serial) begin
      hold_taken = hold_serial;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      stall_left = gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    slot_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result word with none expected, status %0d outstanding %0d",
                 $time, out_status, out_outstanding);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_slot_opened !== want.opened) begin
          $display("%0t: slot_opened expected %0b, got %0b",
                   $time, want.opened, out_slot_opened);
          errors++;
        end
        if (out_slot_sealed !== want.sealed) begin
          $display("%0t: slot_sealed expected %0b, got %0b",
                   $time, want.sealed, out_slot_sealed);
          errors++;
        end
        if (out_drained !== want.drained) begin
          $display("%0t: drained expected %0b, got %0b", $time, want.drained, out_drained);
          errors++;
        end
        if (out_outstanding !== want.outstanding) begin
          $display("%0t: outstanding expected %0d, got %0d",
                   $time, want.outstanding, out_outstanding);
          errors++;
        end
      end
    end
  end

  task automatic test_closed_slots();
    send_word(tdt_pkg::CMD_QUERY, 6'd0, 3'd0, 32'd0);
    send_word(tdt_pkg::CMD_SEAL, 6'd63, 3'd0, 32'd0);
    send_word(tdt_pkg::CMD_RELEASE, 6'd63, 3'd0, COUNT_MAX);
    // not open wins over bad kind
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd42, 3'd5, 32'd1);
  endtask

  task automatic test_counter_limits();
    send_word(tdt_pkg::CMD_OPEN, 6'd0, 3'd0, 32'd0);
    send_word(tdt_pkg::CMD_OPEN, 6'd0, 3'd0, 32'd0);
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd0, 3'd0, 32'd0);
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd0, 3'd3, COUNT_MAX);
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd0, 3'd3, 32'd1);
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd0, 3'd7, 32'd1);
    send_word(tdt_pkg::CMD_RELEASE, 6'd0, 3'd3, 32'd0);
    send_word(tdt_pkg::CMD_RELEASE, 6'd0, 3'd0, 32'd1);
    send_word(tdt_pkg::CMD_RELEASE, 6'd0, 3'd6, 32'd1);
    send_word(tdt_pkg::CMD_RELEASE, 6'd0, 3'd3, COUNT_MAX);
    send_word(tdt_pkg::CMD_QUERY, 6'd0, 3'd5, 32'd0);
  endtask

  task automatic test_seal_and_drain();
    send_word(tdt_pkg::CMD_OPEN, 6'd21, 3'd4, COUNT_MAX);
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd21, 3'd1, 32'd5);
    send_word(tdt_pkg::CMD_SEAL, 6'd21, 3'd6, 32'd0);
    send_word(tdt_pkg::CMD_SEAL, 6'd21, 3'd1, 32'd0);
    // sealed is checked before the kind
    send_word(tdt_pkg::CMD_ACQUIRE, 6'd21, 3'd7, 32'd1);
    send_word(tdt_pkg::CMD_QUERY, 6'd21, 3'd1, 32'd0);
    send_word(tdt_pkg::CMD_RELEASE, 6'd21, 3'd1, 32'd5);
    send_word(CMD_SPARE_LO, 6'd21, 3'd1, 32'd0);
    send_word(CMD_SPARE_HI, 6'd21, 3'd2, 32'd0);
  endtask

  // Output held long while words keep coming, so in_stall has to rise.
  task automatic test_backpressure();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_serial <= hold_serial + 1;
    send_word(tdt_pkg::CMD_OPEN, 6'd30, 3'd0, 32'd0);
    repeat (20) send_word(tdt_pkg::CMD_ACQUIRE, 6'd30, 3'($urandom_range(KINDS - 1)),
                          $urandom_range(99));
  endtask

  task automatic test_random_lifecycles();
    int          live[$];
    int          s, k, pick, start, fresh, r, c;
    logic [2:0]  cmd;
    logic [31:0] cnt, held;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) begin
        case (n / 150)
          0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_gap_pct = 30; rx_stall_pct = 30; end
          2: begin tx_gap_pct = 10; rx_stall_pct = 60; end
          3: begin tx_gap_pct = 60; rx_stall_pct = 10; end
          default: begin tx_gap_pct = 25; rx_stall_pct = 25; end
        endcase
      end
      while (live.size() < 4) begin
        start = $urandom_range(SLOTS - 1);
        fresh = -1;
        for (int j = 0; j < SLOTS; j++)
          if (fresh < 0 && !slot_up[(start + j) % SLOTS]) fresh = (start + j) % SLOTS;
        if (fresh < 0) begin
          live.push_back($urandom_range(SLOTS - 1));
          break;
        end
        send_word(tdt_pkg::CMD_OPEN, 6'(fresh), 3'($urandom_range(KIND_CODE_MAX)),
                  $urandom);
        live.push_back(fresh);
      end
      // noise words
      if ($urandom_range(99) < 12) begin
        send_word(3'($urandom_range(CMD_SPARE_HI)), 6'($urandom_range(SLOTS - 1)),
                  3'($urandom_range(KIND_CODE_MAX)), $urandom);
        continue;
      end
      pick = $urandom_range(live.size() - 1);
      s = live[pick];
      k = $urandom_range(KINDS - 1);
      r = $urandom_range(99);
      if (slot_shut[s]) begin
        // aim releases at a kind that still holds tokens
        start = $urandom_range(KINDS - 1);
        for (int j = 0; j < KINDS; j++)
          if (tokens[s][(start + j) % KINDS] != '0) k = (start + j) % KINDS;
        if (r < 75) cmd = tdt_pkg::CMD_RELEASE;
        else if (r < 85) cmd = tdt_pkg::CMD_ACQUIRE;
        else if (r < 92) cmd = tdt_pkg::CMD_SEAL;
        else cmd = tdt_pkg::CMD_QUERY;
      end else begin
        if (r < 6) cmd = tdt_pkg::CMD_SEAL;
        else if (r < 50) cmd = tdt_pkg::CMD_ACQUIRE;
        else if (r < 85) cmd = tdt_pkg::CMD_RELEASE;
        else if (r < 95) cmd = tdt_pkg::CMD_QUERY;
        else cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      if ($urandom_range(19) == 0) k = $urandom_range(KIND_CODE_MAX, KINDS);
      held = (k < KINDS) ? tokens[s][k] : $urandom;
      c = $urandom_range(99);
      if (cmd == tdt_pkg::CMD_ACQUIRE) begin
        if (c < 55) cnt = $urandom_range(64, 1);
        else if (c < 65) cnt = '0;
        else if (c < 80) cnt = $urandom;
        else cnt = ~held + $urandom_range(1);  // fill to the top or one past
      end else if (cmd == tdt_pkg::CMD_RELEASE) begin
        if (c < 30 || slot_shut[s] && c < 60) cnt = held;
        else if (c < 40) cnt = held + 1;
        else cnt = $urandom_range(held, 0);
      end else begin
        cnt = $urandom;
      end
      send_word(cmd, 6'(s), 3'(k), cnt);
      if (slot_drained(s)) live.delete(pick);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_closed_slots();
    test_counter_limits();
    test_seal_and_drain();
    test_backpressure();
    test_random_lifecycles();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
